@@ rtl/fxalu_pkg.sv @@
// Shared types and constants for the fixed-point ALU.
// Holds command and fault codes and the per-stage side record; no dependencies.
package fxalu_pkg;

	localparam int FracBitsDefault = 8;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_NEG = 3'd2,
		CMD_MUL = 3'd3,
		CMD_DIV = 3'd4,
		CMD_MIN = 3'd5,
		CMD_MAX = 3'd6,
		CMD_NOP = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		FAULT_NONE     = 2'd0,
		FAULT_DIV_ZERO = 2'd1,
		FAULT_DIV_OVF  = 2'd2,
		FAULT_RSVD     = 2'd3
	} fault_t;

	typedef struct packed {
		cmd_t        cmd;
		logic        lt;
		logic        eq;
		logic [31:0] res;
		logic        neg;
		logic        a_pos;
		logic        a_neg;
		logic        b_zero;
		logic [31:0] mag_b;
	} side_t;

endpackage

@@ rtl/fixed_point_alu.sv @@
// Top level of the signed 32-bit fixed-point ALU.
// Depends on fxalu_pkg for command codes, fault codes and the side record.
//
// Usage: a request carries command, operand_a and operand_b on the input
// channel (in_valid/in_stall). Each request yields exactly one result on the
// output channel (out_valid/out_stall) with result, compare flags and fault.
// The pipeline has one input stage holding the multiplier
// and operand compares, one divider stage per quotient bit (32 + FRAC_BITS
// restoring steps), and one stage for rounding and saturation.
// Throughput is one request per cycle unless stalled; the divider is
// fully pipelined. All stages advance together. When the output holds a
// result and the receiver stalls, the whole pipeline holds and in_stall
// rises; empty stages still fill while the output is empty.
// Reset clears all valid bits; the pipeline starts empty.
module fixed_point_alu #(
	parameter int FRAC_BITS = fxalu_pkg::FracBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result,
	output logic               a_less_than_b,
	output logic               a_equal_b,
	output logic [1:0]         fault
);
	import fxalu_pkg::*;

	localparam int QW = 32 + FRAC_BITS;

	logic adv;

	logic               vld_s1;
	side_t              side_s1;
	logic signed [63:0] prod_s1;
	logic [31:0]        mag_a_s1;

	logic          vld_d  [QW];
	side_t         side_d [QW];
	logic [QW-1:0] num_d  [QW];
	logic [31:0]   rem_d  [QW];
	logic [QW-1:0] quo_d  [QW];

	side_t         side_n [QW];
	logic [QW-1:0] num_n  [QW];
	logic [31:0]   rem_n  [QW];
	logic [QW-1:0] quo_n  [QW];

	logic        vld_s3;
	logic [31:0] res_s3;
	logic        lt_s3;
	logic        eq_s3;
	fault_t      fault_s3;

	assign adv      = !out_stall || !vld_s3;
	assign in_stall = !adv;

	side_t side_in;
	always_comb begin
		logic signed [31:0] a;
		logic signed [31:0] b;
		a = operand_a;
		b = operand_b;
		side_in.cmd    = cmd_t'(command);
		side_in.lt     = a < b;
		side_in.eq     = a == b;
		side_in.neg    = a[31] != b[31];
		side_in.a_pos  = !a[31] && (a != 32'sd0);
		side_in.a_neg  = a[31];
		side_in.b_zero = b == 32'sd0;
		side_in.mag_b  = b[31] ? 32'(-b) : 32'(b);
		unique case (cmd_t'(command))
			CMD_ADD: side_in.res = 32'(a + b);
			CMD_SUB: side_in.res = 32'(a - b);
			CMD_NEG: side_in.res = 32'(-a);
			CMD_MIN: side_in.res = (a < b) ? a : b;
			CMD_MAX: side_in.res = (a > b) ? a : b;
			default: side_in.res = 32'd0;
		endcase
	end

	always_comb begin
		logic [QW-1:0] num_p;
		logic [31:0]   rem_p;
		logic [QW-1:0] quo_p;
		logic [32:0]   rr;
		logic          ge;
		for (int i = 0; i < QW; i++) begin
			if (i == 0) begin
				side_n[i] = side_s1;
				if (side_s1.cmd == CMD_MUL) begin
					side_n[i].res = 32'(prod_s1 >>> FRAC_BITS);
				end
				num_p = {mag_a_s1, {FRAC_BITS{1'b0}}};
				rem_p = 32'd0;
				quo_p = '0;
			end else begin
				side_n[i] = side_d[i-1];
				num_p = num_d[i-1];
				rem_p = rem_d[i-1];
				quo_p = quo_d[i-1];
			end
			rr = {rem_p, num_p[QW-1]};
			ge = rr >= {1'b0, side_n[i].mag_b};
			rem_n[i] = ge ? 32'(rr - {1'b0, side_n[i].mag_b}) : rr[31:0];
			num_n[i] = {num_p[QW-2:0], 1'b0};
			quo_n[i] = {quo_p[QW-2:0], ge};
		end
	end

	logic [31:0] res_fin;
	fault_t      fault_fin;
	always_comb begin
		side_t       sd;
		logic        rnd;
		logic [QW:0] qr;
		sd  = side_d[QW-1];
		rnd = {rem_d[QW-1], 1'b0} >= {1'b0, sd.mag_b};
		qr  = (QW+1)'(quo_d[QW-1]) + (QW+1)'(rnd);
		res_fin   = sd.res;
		fault_fin = FAULT_NONE;
		if (sd.cmd == CMD_DIV) begin
			if (sd.b_zero) begin
				fault_fin = FAULT_DIV_ZERO;
				res_fin = sd.a_pos ? 32'h7FFFFFFF : (sd.a_neg ? 32'h80000000 : 32'd0);
			end else if (!sd.neg) begin
				if (qr > (QW+1)'(64'h7FFFFFFF)) begin
					fault_fin = FAULT_DIV_OVF;
					res_fin = 32'h7FFFFFFF;
				end else begin
					res_fin = qr[31:0];
				end
			end else begin
				if (qr > (QW+1)'(64'h80000000)) begin
					fault_fin = FAULT_DIV_OVF;
					res_fin = 32'h80000000;
				end else begin
					res_fin = 32'd0 - qr[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < QW; i++) begin
				vld_d[i] <= 1'b0;
			end
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1   <= in_valid;
			vld_d[0] <= vld_s1;
			for (int i = 1; i < QW; i++) begin
				vld_d[i] <= vld_d[i-1];
			end
			vld_s3 <= vld_d[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1  <= side_in;
			prod_s1  <= operand_a * operand_b;
			mag_a_s1 <= operand_a[31] ? 32'(-operand_a) : 32'(operand_a);
			for (int i = 0; i < QW; i++) begin
				side_d[i] <= side_n[i];
				num_d[i]  <= num_n[i];
				rem_d[i]  <= rem_n[i];
				quo_d[i]  <= quo_n[i];
			end
			res_s3   <= res_fin;
			lt_s3    <= side_d[QW-1].lt;
			eq_s3    <= side_d[QW-1].eq;
			fault_s3 <= fault_fin;
		end
	end

	assign out_valid     = vld_s3;
	assign result        = res_s3;
	assign a_less_than_b = lt_s3;
	assign a_equal_b     = eq_s3;
	assign fault         = fault_s3;

endmodule
